FILE: hdl/sih_pkg.sv
package sih_pkg;

  localparam int unsigned TableSlots     = 256;
  localparam int unsigned SlotW          = 8;
  localparam int unsigned MaxBytes       = 32;
  localparam int unsigned ByteIdxW       = 5;
  localparam int unsigned LenW           = 6;
  localparam int unsigned HashW          = 32;
  localparam int unsigned FoldW          = 22;
  localparam int unsigned BytesAddrW     = SlotW + ByteIdxW;
  localparam logic [HashW-1:0] HashBasis = 32'd2166136261;
  localparam logic [HashW-1:0] HashPrime = 32'd16777619;
  localparam logic [8:0] CountMax        = 9'd511;

  typedef enum logic [1:0] {
    StFound    = 2'd0,
    StInserted = 2'd1,
    StFull     = 2'd2,
    StTooLong  = 2'd3
  } status_e;

  // fold the 32-bit hash to 22 bits
  function automatic logic [FoldW-1:0] fold_hash(input logic [HashW-1:0] h);
    logic [HashW-1:0] x;
    x = h ^ (h >> FoldW);
    return x[FoldW-1:0];
  endfunction

endpackage

FILE: hdl/string_intern_hash_table.sv
// probing: a string end starts at its home slot; each probe checks the stored length, then
//   compares the bytes one by one for a match, or copies them one by one into a free slot;
//   a too-long string skips the probe, and each rejected slot moves the probe to the next slot
// throughput: one byte item per cycle; a string end holds the input until its result is
//   loaded, which waits while the previous result has not been taken
// reset: hash state and all valid bits clear at once, no clearing pass
module string_intern_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_byte[7:0]
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // slot_index[7:0], symbol_hash[29:8], status[31:30]
);

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SLook  = 8'b00000010,
    SRdPnd = 8'b00000100,
    SCmp   = 8'b00001000,
    SCpRd  = 8'b00010000,
    SCpWr  = 8'b00100000,
    SOut   = 8'b01000000,
    SWait  = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic                          take;
  logic [sih_pkg::HashW-1:0]     hash;
  logic [sih_pkg::LenW-1:0]      len;
  logic                          too_long;
  logic                          hs_pend_we;
  logic [sih_pkg::ByteIdxW-1:0]  hs_pend_addr;
  logic                          clear_str;
  logic [sih_pkg::FoldW-1:0]     fold_now;

  logic [sih_pkg::SlotW-1:0]     slot_q, slot_d;
  logic [sih_pkg::SlotW:0]       probes_q, probes_d;
  logic [sih_pkg::LenW-1:0]      bi_q, bi_d;
  logic [7:0]                    pbyte_q, pbyte_d;
  logic [sih_pkg::TableSlots-1:0] valid_q;
  logic                          set_valid;
  logic [8:0]                    count_q;
  logic [sih_pkg::FoldW-1:0]     fold_q;
  sih_pkg::status_e              status_q, status_d;
  logic [sih_pkg::SlotW-1:0]     res_slot_q, res_slot_d;

  logic [31:0]                   out_q;
  logic                          out_v_q;

  logic                          pend_we;
  logic [sih_pkg::ByteIdxW-1:0]  pend_waddr, pend_raddr;
  logic [7:0]                    pend_wdata, pend_rdata;
  logic                          len_we;
  logic [sih_pkg::LenW-1:0]      len_rdata;
  logic                          byt_we;
  logic [sih_pkg::BytesAddrW-1:0] byt_addr;
  logic [7:0]                    byt_rdata;

  assign s_axis_tready = (state_q == SIdle);
  assign take          = s_axis_tvalid && s_axis_tready;

  sih_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .has_byte_i (s_axis_tuser),
    .char_byte_i(s_axis_tdata),
    .clear_i    (clear_str),
    .hash_o     (hash),
    .len_o      (len),
    .too_long_o (too_long),
    .pend_we_o  (hs_pend_we),
    .pend_addr_o(hs_pend_addr)
  );

  assign fold_now = sih_pkg::fold_hash(hash);

  // string bytes gathered so far
  assign pend_we    = hs_pend_we;
  assign pend_waddr = hs_pend_addr;
  assign pend_wdata = s_axis_tdata;
  assign pend_raddr = bi_q[sih_pkg::ByteIdxW-1:0];

  sih_ram #(.Width(8), .Depth(sih_pkg::MaxBytes)) u_pend (
    .clk_i(clk_i), .we_i(pend_we), .waddr_i(pend_waddr), .wdata_i(pend_wdata),
    .raddr_i(pend_raddr), .rdata_o(pend_rdata)
  );

  // length read follows the slot being loaded so the first probe sees its own slot
  sih_ram #(.Width(sih_pkg::LenW), .Depth(sih_pkg::TableSlots)) u_len (
    .clk_i(clk_i), .we_i(len_we), .waddr_i(slot_q), .wdata_i(len),
    .raddr_i(slot_d), .rdata_o(len_rdata)
  );

  assign byt_addr = {slot_q, bi_q[sih_pkg::ByteIdxW-1:0]};

  sih_ram #(.Width(8), .Depth(sih_pkg::TableSlots * sih_pkg::MaxBytes)) u_bytes (
    .clk_i(clk_i), .we_i(byt_we), .waddr_i(byt_addr), .wdata_i(pbyte_q),
    .raddr_i(byt_addr), .rdata_o(byt_rdata)
  );

  // probe sequencer
  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    probes_d   = probes_q;
    bi_d       = bi_q;
    pbyte_d    = pbyte_q;
    status_d   = status_q;
    res_slot_d = res_slot_q;
    len_we     = 1'b0;
    byt_we     = 1'b0;
    set_valid  = 1'b0;
    clear_str  = 1'b0;
    case (state_q)
      SIdle: begin
        if (take && s_axis_tlast) begin
          state_d  = SLook;
          probes_d = '0;
        end
      end
      // hash and length now include the last byte; len ram read issued at slot_d
      SLook: begin
        if (probes_q == '0) begin
          slot_d = fold_now[sih_pkg::SlotW-1:0];
        end
        bi_d = '0;
        if (too_long) begin
          status_d = sih_pkg::StTooLong; res_slot_d = '0; state_d = SOut;
        end else if (probes_q == (sih_pkg::SlotW+1)'(sih_pkg::TableSlots)) begin
          status_d = sih_pkg::StFull; res_slot_d = '0; state_d = SOut;
        end else if (probes_q == '0) begin
          state_d = SLook;
          probes_d = probes_q;
          probes_d[sih_pkg::SlotW] = 1'b0;
          state_d = SRdPnd;
        end else begin
          state_d = SRdPnd;
        end
      end
      // byte rams now read at slot_q and index bi_q
      SRdPnd: begin
        if (!valid_q[slot_q]) begin
          status_d = sih_pkg::StInserted; res_slot_d = slot_q;
          len_we = 1'b1; set_valid = 1'b1;
          state_d = (len == '0) ? SOut : SCpRd;
        end else if (len_rdata != len) begin
          state_d = SWait;
        end else if (len == '0) begin
          status_d = sih_pkg::StFound; res_slot_d = slot_q; state_d = SOut;
        end else begin
          state_d = SCmp;
        end
      end
      SCmp: begin
        if (pend_rdata != byt_rdata) begin
          state_d = SWait;
        end else if (bi_q + 1'b1 == len) begin
          status_d = sih_pkg::StFound; res_slot_d = slot_q; state_d = SOut;
        end else begin
          bi_d = bi_q + 1'b1;
          state_d = SRdPnd;
        end
      end
      SCpRd: begin
        pbyte_d = pend_rdata;
        state_d = SCpWr;
      end
      SCpWr: begin
        byt_we = 1'b1;
        if (bi_q + 1'b1 == len) begin
          state_d = SOut;
        end else begin
          bi_d = bi_q + 1'b1;
          state_d = SRdPnd;
        end
      end
      // advance to next slot
      SWait: begin
        slot_d   = slot_q + 1'b1;
        probes_d = probes_q + 1'b1;
        bi_d     = '0;
        state_d  = SLook;
      end
      SOut: begin
        if (!out_v_q || m_axis_tready) begin
          clear_str = 1'b1;
          state_d   = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // copy reads pass through SRdPnd while in insert mode
  logic copying_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) copying_q <= 1'b0;
    else if (state_q == SIdle) copying_q <= 1'b0;
    else if (set_valid) copying_q <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      probes_q <= '0;
      valid_q  <= '0;
      count_q  <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= copying_q && state_q == SRdPnd ? SCpRd : state_d;
      probes_q <= probes_d;
      if (set_valid && !copying_q) begin
        valid_q[slot_q] <= 1'b1;
        if (count_q != sih_pkg::CountMax) count_q <= count_q + 1'b1;
      end
      if (clear_str) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    bi_q       <= bi_d;
    pbyte_q    <= pbyte_d;
    status_q   <= (copying_q && state_q == SRdPnd) ? status_q : status_d;
    res_slot_q <= (copying_q && state_q == SRdPnd) ? res_slot_q : res_slot_d;
    if (state_q == SLook && probes_q == '0) fold_q <= fold_now;
    if (clear_str) out_q <= {status_q, fold_q, res_slot_q};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // assertions
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !s_axis_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("out changed");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= 0 && count_q <= sih_pkg::CountMax) else $error("count range");
  a_err_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[31]) |-> (m_axis_tdata[7:0] == 8'd0)) else $error("err slot");

endmodule

FILE: hdl/sih_ram.sv
module sih_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/sih_hash.sv
module sih_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic                          has_byte_i,
  input  logic [7:0]                    char_byte_i,
  input  logic                          clear_i,
  output logic [sih_pkg::HashW-1:0]     hash_o,
  output logic [sih_pkg::LenW-1:0]      len_o,
  output logic                          too_long_o,
  output logic                          pend_we_o,
  output logic [sih_pkg::ByteIdxW-1:0]  pend_addr_o
);

  logic [sih_pkg::HashW-1:0] hash_q, hash_d;
  logic [sih_pkg::LenW-1:0]  len_q, len_d;
  logic                      tl_q, tl_d;
  logic                      room;

  assign room = len_q < sih_pkg::LenW'(sih_pkg::MaxBytes);

  // running hash, length and overflow flag
  always_comb begin
    hash_d = hash_q;
    len_d  = len_q;
    tl_d   = tl_q;
    if (take_i && has_byte_i) begin
      hash_d = (hash_q ^ {24'd0, char_byte_i}) * sih_pkg::HashPrime;
      if (room) len_d = len_q + 1'b1;
      else      tl_d  = 1'b1;
    end
    if (clear_i) begin
      hash_d = sih_pkg::HashBasis;
      len_d  = '0;
      tl_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= sih_pkg::HashBasis;
      len_q  <= '0;
      tl_q   <= 1'b0;
    end else begin
      hash_q <= hash_d;
      len_q  <= len_d;
      tl_q   <= tl_d;
    end
  end

  assign hash_o      = hash_q;
  assign len_o       = len_q;
  assign too_long_o  = tl_q;
  assign pend_we_o   = take_i && has_byte_i && room;
  assign pend_addr_o = len_q[sih_pkg::ByteIdxW-1:0];

endmodule
